// File: rtl/dstq_pkg.sv
// shared types and constants for the deadline sorted timer queue
package dstq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int CNT_W_DEF       = $clog2(QUEUE_DEPTH_DEF + 1);
    localparam int TICK_W          = 32;
    localparam int DELAY_W         = 31;
    localparam int CODE_W          = 16;
    localparam int KIND_W          = 2;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_ENQUEUE = 2'd1,
        KIND_CONSUME = 2'd2,
        KIND_NOP     = 2'd3
    } t_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_DONE
    } t_state;

    // operations on the slot array
    typedef enum logic [2:0] {
        SOP_HOLD,
        SOP_ROTATE,
        SOP_INSERT,
        SOP_REMOVE,
        SOP_DROP
    } t_slot_op;

    typedef struct packed {
        logic [TICK_W-1:0]  start;
        logic [DELAY_W-1:0] delay;
        logic [CODE_W-1:0]  code;
        logic               active;
    } t_slot_entry;

endpackage

// File: rtl/dstq_if.sv
// request and result channel interfaces
interface dstq_in_if;
    import dstq_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CODE_W-1:0]  task_code;
    logic [DELAY_W-1:0] delay_ticks;

    modport source (output valid, kind, task_code, delay_ticks, input ready);
    modport sink   (input valid, kind, task_code, delay_ticks, output ready);
endinterface

interface dstq_out_if #(
    parameter int CNT_W = dstq_pkg::CNT_W_DEF
);
    import dstq_pkg::*;

    logic              valid;
    logic              ready;
    logic              head_due;
    logic [CODE_W-1:0] removed_code;
    logic              removed_valid;
    logic              displaced;
    logic [CNT_W-1:0]  active_count;

    modport source (output valid, head_due, removed_code, removed_valid, displaced,
                    active_count, input ready);
    modport sink   (input valid, head_due, removed_code, removed_valid, displaced,
                    active_count, output ready);
endinterface

// File: rtl/dstq_cmp.sv
// shared wrap-aware deadline comparator
module dstq_cmp (
    input  dstq_pkg::t_slot_entry         i_head,
    input  logic [dstq_pkg::TICK_W-1:0]   i_new_deadline,
    output logic                          o_later
);
    import dstq_pkg::*;

    logic [TICK_W-1:0] head_deadline;
    logic [TICK_W-1:0] diff;

    assign head_deadline = i_head.start + {1'b0, i_head.delay};
    assign diff          = head_deadline - i_new_deadline;
    // later when the difference is positive as a signed value
    assign o_later       = (diff != '0) && !diff[TICK_W-1];

endmodule

// File: rtl/dstq_slots.sv
// slot array with rotate, insert, remove and drop operations
module dstq_slots #(
    parameter int QUEUE_DEPTH = dstq_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dstq_pkg::t_slot_op     i_op,
    input  logic [IDX_W-1:0]       i_pos,
    input  dstq_pkg::t_slot_entry  i_new,
    output dstq_pkg::t_slot_entry  o_head
);
    import dstq_pkg::*;

    t_slot_entry r_slot   [QUEUE_DEPTH];
    logic        r_active [QUEUE_DEPTH];

    assign o_head = '{start:  r_slot[0].start,
                      delay:  r_slot[0].delay,
                      code:   r_slot[0].code,
                      active: r_active[0]};

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_slot
        localparam int NEXT = (gi + 1) % QUEUE_DEPTH;
        localparam int PREV = (gi == 0) ? 0 : gi - 1;

        // payload, no reset
        always_ff @(posedge i_clk) begin
            case (i_op)
                SOP_ROTATE: r_slot[gi] <= r_slot[NEXT];
                SOP_REMOVE: begin
                    if (gi < QUEUE_DEPTH - 1) begin
                        r_slot[gi] <= r_slot[NEXT];
                    end
                end
                SOP_INSERT: begin
                    if (i_pos == IDX_W'(gi)) begin
                        r_slot[gi] <= i_new;
                    end else if (gi > 0 && i_pos < IDX_W'(gi)) begin
                        r_slot[gi] <= r_slot[PREV];
                    end
                end
                default: ;
            endcase
        end

        // active bits
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_active[gi] <= 1'b0;
            end else begin
                case (i_op)
                    SOP_ROTATE: r_active[gi] <= r_active[NEXT];
                    SOP_REMOVE: begin
                        if (gi < QUEUE_DEPTH - 1) begin
                            r_active[gi] <= r_active[NEXT];
                        end else begin
                            r_active[gi] <= 1'b0;
                        end
                    end
                    SOP_DROP: begin
                        if (gi == QUEUE_DEPTH - 1) begin
                            r_active[gi] <= 1'b0;
                        end
                    end
                    SOP_INSERT: begin
                        if (i_pos == IDX_W'(gi)) begin
                            r_active[gi] <= 1'b1;
                        end else if (gi > 0 && i_pos < IDX_W'(gi)) begin
                            r_active[gi] <= r_active[PREV];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: rtl/deadline_sorted_timer_queue_top.sv
// deadline sorted timer queue: sequencer, tick counter and result register
// tick, consume and no-op requests pass straight from idle to the done state
// enqueue requests first search: one compare per slot through the
//   shared comparator while the slot array rotates once, then the insert and done states
// one request at a time: a new request is taken only in the idle state; a result left
//   waiting holds the next request in its done state until the output is taken
// reset (synchronous, active low) clears the tick counter, count, active bits and sequencer
module deadline_sorted_timer_queue_top #(
    parameter int QUEUE_DEPTH = dstq_pkg::QUEUE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dstq_in_if.sink   i_in,
    dstq_out_if.source o_out
);
    import dstq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // sequencer
    t_state r_state, n_state;

    // request context
    logic [TICK_W-1:0]  r_tick;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_limit;      // active entries taking part in the search
    logic [CODE_W-1:0]  r_code;
    logic [DELAY_W-1:0] r_delay;
    logic [TICK_W-1:0]  r_new_dl;     // deadline of the entry being inserted
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_pos;
    logic               r_found;
    logic [CODE_W-1:0]  r_removed_code;
    logic               r_removed_valid;
    logic               r_displaced;

    // result register
    logic               r_out_valid;
    logic               r_head_due;
    logic [CODE_W-1:0]  r_out_code;
    logic               r_out_removed;
    logic               r_out_displaced;
    logic [CNT_W-1:0]   r_out_count;

    logic         accept;
    logic         out_free;
    t_slot_op     slot_op;
    t_slot_entry  head;
    t_slot_entry  new_entry;
    logic         later;
    logic         head_due;
    logic [TICK_W-1:0] elapsed;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign new_entry = '{start: r_tick, delay: r_delay, code: r_code, active: 1'b1};

    dstq_slots #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (slot_op),
        .i_pos   (r_pos),
        .i_new   (new_entry),
        .o_head  (head)
    );

    // one comparator, walked over the slots as they rotate past the head
    dstq_cmp u_cmp (
        .i_head         (head),
        .i_new_deadline (r_new_dl),
        .o_later        (later)
    );

    // head is due once unsigned elapsed ticks reach its delay
    assign elapsed  = r_tick - head.start;
    assign head_due = head.active && (elapsed >= {1'b0, head.delay});

    // next state and slot operation
    always_comb begin
        n_state    = r_state;
        slot_op    = SOP_HOLD;
        i_in.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (accept) begin
                    case (t_kind'(i_in.kind))
                        KIND_ENQUEUE: begin
                            // full queue drops the latest deadline first
                            if (r_count == FULL_CNT) begin
                                slot_op = SOP_DROP;
                            end
                            n_state = ST_SCAN;
                        end
                        KIND_CONSUME: begin
                            if (head.active) begin
                                slot_op = SOP_REMOVE;
                            end
                            n_state = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                slot_op = SOP_ROTATE;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                slot_op = SOP_INSERT;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && t_kind'(i_in.kind) == KIND_TICK) begin
                r_tick <= r_tick + 1'b1;
            end
            if (accept && t_kind'(i_in.kind) == KIND_CONSUME && head.active) begin
                r_count <= r_count - 1'b1;
            end
            if (r_state == ST_INSERT) begin
                r_count <= r_limit + 1'b1;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request context and search
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code   <= i_in.task_code;
            r_delay  <= i_in.delay_ticks;
            r_new_dl <= r_tick + {1'b0, i_in.delay_ticks};
            r_idx    <= '0;
            r_found  <= 1'b0;
            // enqueue on a full queue searches one entry fewer
            if (t_kind'(i_in.kind) == KIND_ENQUEUE && r_count == FULL_CNT) begin
                r_displaced <= 1'b1;
                r_limit     <= FULL_CNT - 1'b1;
                r_pos       <= LAST_IDX;
            end else begin
                r_displaced <= 1'b0;
                r_limit     <= r_count;
                r_pos       <= r_count[IDX_W-1:0];
            end
            if (t_kind'(i_in.kind) == KIND_CONSUME && head.active) begin
                r_removed_code  <= head.code;
                r_removed_valid <= 1'b1;
            end else begin
                r_removed_code  <= '0;
                r_removed_valid <= 1'b0;
            end
        end else if (r_state == ST_SCAN) begin
            r_idx <= r_idx + 1'b1;
            // first active entry whose deadline is later takes the new slot
            if (!r_found && CNT_W'(r_idx) < r_limit && later) begin
                r_found <= 1'b1;
                r_pos   <= r_idx;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_head_due      <= head_due;
            r_out_code      <= r_removed_code;
            r_out_removed   <= r_removed_valid;
            r_out_displaced <= r_displaced;
            r_out_count     <= r_count;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.head_due      = r_head_due;
    assign o_out.removed_code  = r_out_code;
    assign o_out.removed_valid = r_out_removed;
    assign o_out.displaced     = r_out_displaced;
    assign o_out.active_count  = r_out_count;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("active count beyond queue depth");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> (head.active == (r_count != '0)))
        else $error("head active bit disagrees with active count");

    a_displaced_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.displaced |-> o_out.active_count == FULL_CNT)
        else $error("displacement reported on a queue that is not full");

    a_scan_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN && r_idx != LAST_IDX |=> r_state == ST_SCAN)
        else $error("search left before a full rotation");

    a_removed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.removed_valid |-> o_out.removed_code == '0)
        else $error("removed code set without a removal");

endmodule

// File: tb/sv/tb_timer_queue_checker.sv
`timescale 1ns / 1ps
// timer queue checker: mirrors the deadline ordered slots and compares every result
module tb_timer_queue_checker
    import dstq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dstq_in_if   i_req_mon,
    dstq_out_if  i_rsp_mon,
    output int   o_fail_cnt,
    output int   o_pending_cnt
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic              head_due;
        logic [CODE_W-1:0] removed_code;
        logic              removed_valid;
        logic              displaced;
        logic [CNT_W-1:0]  active_count;
    } t_timer_result;

    logic [TICK_W-1:0] tick_now_q;
    t_slot_entry       slot_q [DEPTH];
    t_timer_result     pending_results [$];
    int                fail_total;

    assign o_fail_cnt = fail_total;

    function automatic int active_slots();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (slot_q[i].active) n++;
        end
        return n;
    endfunction

    // wrap-aware: slot deadline strictly later than (start, delay)
    function automatic bit deadline_later(t_slot_entry s, logic [TICK_W-1:0] start,
                                          logic [DELAY_W-1:0] delay);
        logic [TICK_W-1:0] diff;
        diff = (s.start - start) + ({1'b0, s.delay} - {1'b0, delay});
        return (diff != '0) && !diff[TICK_W-1];
    endfunction

    function automatic void clear_timer_slots();
        tick_now_q = '0;
        for (int i = 0; i < DEPTH; i++) slot_q[i] = '0;
    endfunction

    function automatic t_timer_result advance_timer_queue(t_kind kind, logic [CODE_W-1:0] code,
                                                         logic [DELAY_W-1:0] delay);
        t_timer_result res;
        int            n;
        int            pos;
        bit            found;
        res   = '0;
        found = 1'b0;
        case (kind)
            KIND_TICK: begin
                tick_now_q = tick_now_q + 1'b1;
            end
            KIND_ENQUEUE: begin
                n = active_slots();
                if (n >= DEPTH) begin
                    res.displaced = 1'b1;
                    n = DEPTH - 1;
                    slot_q[n].active = 1'b0;
                end
                pos = n;
                for (int i = 0; i < n; i++) begin
                    if (!found && deadline_later(slot_q[i], tick_now_q, delay)) begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (int i = n; i > pos; i--) slot_q[i] = slot_q[i-1];
                slot_q[pos] = '{start: tick_now_q, delay: delay, code: code, active: 1'b1};
            end
            KIND_CONSUME: begin
                if (slot_q[0].active) begin
                    res.removed_code  = slot_q[0].code;
                    res.removed_valid = 1'b1;
                    for (int i = 0; i < DEPTH - 1; i++) slot_q[i] = slot_q[i+1];
                    slot_q[DEPTH-1] = '0;
                end
            end
            default: ;
        endcase
        res.head_due = slot_q[0].active &&
                       ((tick_now_q - slot_q[0].start) >= {1'b0, slot_q[0].delay});
        res.active_count = CNT_W'(active_slots());
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        if (!i_rst_n) begin
            clear_timer_slots();
            pending_results.delete();
            fail_total = 0;
        end else begin
            if (i_req_mon.valid && i_req_mon.ready) begin
                pending_results.push_back(advance_timer_queue(t_kind'(i_req_mon.kind),
                    i_req_mon.task_code, i_req_mon.delay_ticks));
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = '{head_due: i_rsp_mon.head_due, removed_code: i_rsp_mon.removed_code,
                        removed_valid: i_rsp_mon.removed_valid,
                        displaced: i_rsp_mon.displaced, active_count: i_rsp_mon.active_count};
                if (pending_results.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: result with no request outstanding: %p", $time, got);
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.head_due !== want.head_due || got.removed_code !== want.removed_code
                        || got.removed_valid !== want.removed_valid
                        || got.displaced !== want.displaced
                        || got.active_count !== want.active_count) begin
                        if (fail_total < 10)
                            $display({"%0t: mismatch (exp/got) due %b/%b code %h/%h ",
                                      "rvalid %b/%b displaced %b/%b count %0d/%0d"}, $time,
                                     want.head_due, got.head_due,
                                     want.removed_code, got.removed_code,
                                     want.removed_valid, got.removed_valid,
                                     want.displaced, got.displaced,
                                     want.active_count, got.active_count);
                        fail_total++;
                    end
                end
            end
        end
        o_pending_cnt <= pending_results.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top: request stimulus, result back-pressure, watchdog and verdict
module tb_top;
    import dstq_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_REQS  = 1150;
    // slowest legal run stays well inside this watchdog limit
    localparam int CYCLE_LIMIT  = 400_000;
    // long receiver hold-off so the block fills and stalls its request side
    localparam int HOLD_AT      = 1500;
    localparam int HOLD_LEN     = 400;
    // drain for longer than one enqueue takes from acceptance to result
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH_DEF + 8;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending_cnt;
    int   cycle_cnt;

    dstq_in_if  req_if ();
    dstq_out_if rsp_if ();

    deadline_sorted_timer_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    tb_timer_queue_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_mon     (req_if),
        .i_rsp_mon     (rsp_if),
        .o_fail_cnt    (fail_cnt),
        .o_pending_cnt (pending_cnt)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // present one request at a falling edge and hold it until accepted;
    // returns on the falling edge after the accepting rising edge
    task automatic send_request(input t_kind kind, input logic [CODE_W-1:0] code,
                                input logic [DELAY_W-1:0] delay);
        req_if.valid       <= 1'b1;
        req_if.kind        <= kind;
        req_if.task_code   <= code;
        req_if.delay_ticks <= delay;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // idle gap with no request offered; n > 0
    task automatic idle_cycles(input int n);
        req_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // burst flavors: 0 fill the queue, 1 drain it, 2 let time run, 3 even mix
    function automatic t_kind pick_kind(input int flavor);
        int r;
        int enq_pct;
        int tick_pct;
        int cons_pct;
        r = $urandom_range(0, 99);
        case (flavor)
            0:       begin enq_pct = 60; tick_pct = 20; cons_pct = 15; end
            1:       begin enq_pct = 15; tick_pct = 25; cons_pct = 55; end
            2:       begin enq_pct = 20; tick_pct = 60; cons_pct = 15; end
            default: begin enq_pct = 30; tick_pct = 30; cons_pct = 30; end
        endcase
        if (r < enq_pct) return KIND_ENQUEUE;
        if (r < enq_pct + tick_pct) return KIND_TICK;
        if (r < enq_pct + tick_pct + cons_pct) return KIND_CONSUME;
        return KIND_NOP;
    endfunction

    // mostly short delays so heads come due and deadlines tie,
    // plus full-range and near-max delays for the wrap-aware compare
    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return DELAY_W'($urandom_range(0, 30));
        if (r < 75) return DELAY_W'($urandom_range(0, 300));
        if (r < 90) return DELAY_W'($urandom);
        return {DELAY_W{1'b1}} - DELAY_W'($urandom_range(0, 3));
    endfunction

    // request side: reset, directed requests, random bursts, drain, verdict
    initial begin : stimulus
        int    sent;
        int    burst_len;
        int    flavor;
        int    gap;
        t_kind kind;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.kind        = KIND_NOP;
        req_if.task_code   = '0;
        req_if.delay_ticks = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // consume on an empty queue and the unused kind
        send_request(KIND_CONSUME, 16'h0000, '0);
        send_request(KIND_NOP, 16'hffff, {DELAY_W{1'b1}});
        // zero delay is due at once, max delay sorts behind it
        send_request(KIND_ENQUEUE, 16'h0000, '0);
        send_request(KIND_ENQUEUE, 16'hffff, {DELAY_W{1'b1}});
        send_request(KIND_ENQUEUE, 16'h1111, 31'd5);
        send_request(KIND_TICK, 16'h0000, '0);
        // same deadline as the previous entry: the older one stays first
        send_request(KIND_ENQUEUE, 16'h2222, 31'd4);
        send_request(KIND_ENQUEUE, 16'h4444, 31'h4000_0000);
        send_request(KIND_ENQUEUE, 16'h5555, 31'd2);
        send_request(KIND_ENQUEUE, 16'h6666, 31'd3);
        send_request(KIND_ENQUEUE, 16'h7777, 31'd1);
        // queue is full now: drop the latest entry, once mid-queue, once at the tail
        send_request(KIND_ENQUEUE, 16'h8888, '0);
        send_request(KIND_ENQUEUE, 16'h9999, {DELAY_W{1'b1}});
        send_request(KIND_TICK, 16'h0000, '0);
        send_request(KIND_TICK, 16'h0000, '0);
        // drain everything and one more on the empty queue
        repeat (QUEUE_DEPTH_DEF + 1) send_request(KIND_CONSUME, 16'h0000, '0);

        sent = 0;
        while (sent < RANDOM_REQS) begin
            burst_len = $urandom_range(1, 24);
            flavor    = $urandom_range(0, 3);
            for (int k = 0; k < burst_len && sent < RANDOM_REQS; k++) begin
                kind = pick_kind(flavor);
                send_request(kind, CODE_W'($urandom_range(0, 65535)), pick_delay());
                sent++;
            end
            // back-to-back bursts about a quarter of the time
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) idle_cycles(gap);
        end
        req_if.valid <= 1'b0;

        // all results in, then keep the clock running to catch anything stray
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_cnt == 0)
            $display("deadline_sorted_timer_queue_top test passed");
        else
            $display("deadline_sorted_timer_queue_top test failed");
        $finish;
    end

    // result side: ready follows a pattern that changes per segment,
    // with one long hold-off while the request side keeps pushing
    initial begin : result_side
        int mode;
        int seg_len;
        int rsp_cycles;
        bit held;
        rsp_if.ready = 1'b0;
        rsp_cycles   = 0;
        held         = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 200);
            repeat (seg_len) begin
                @(negedge i_clk);
                rsp_cycles++;
                if (!held && rsp_cycles >= HOLD_AT) begin
                    held = 1'b1;
                    rsp_if.ready <= 1'b0;
                    repeat (HOLD_LEN) @(negedge i_clk);
                    rsp_cycles += HOLD_LEN;
                end
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
                    2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog on total run length
    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("deadline_sorted_timer_queue_top test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/dstq_pkg.sv
rtl/dstq_if.sv
rtl/dstq_cmp.sv
rtl/dstq_slots.sv
rtl/deadline_sorted_timer_queue_top.sv
tb/sv/tb_timer_queue_checker.sv
tb/sv/tb_top.sv
